@@ hw/rtl/rrm_pkg.sv @@
`default_nettype none

package rrm_pkg;

    localparam int MAX_MEMBERS = 16;
    localparam int IDX_W       = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
    localparam int ID_W        = 16;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_LIST   = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NEXT   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIST_RD,
        S_LIST_EMIT,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RM_DONE,
        S_NX_RD,
        S_NX_EMIT,
        S_REPLY
    } state_t;

    typedef struct packed {
        func_t            func;
        logic [ID_W-1:0]  player_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]  member_id;
        status_t          status;
        logic             last;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/rrm_ram.sv @@
`default_nettype none

module rrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/round_robin_member_ring_unit.sv @@
// Round-robin member ring: an ordered ring of up to MAX_MEMBERS ids with a turn pointer.
// Requests enter on req (req_valid/req_ready), results leave on rsp (rsp_valid/rsp_ready).
// Operations are add, list all, remove by id and next turn; each result carries last = 1
// on the final result of its request, and list gives one result per stored id.
// The block handles one request at a time and holds req_ready low until the request's
// final result has been placed in the output register.
// The ids live in a single-port-read memory with a registered read. Add writes the id and
// replies; next turn reads and emits the turn entry; list reads and emits each stored id;
// remove scans up to the match, moves each later entry down one place, then updates count,
// turn and reply. A failed remove scans every id; an empty ring answers with no read.
// A result waits in the output register while rsp_ready is low; the sequencer stalls until
// that register is free, and nothing is lost or repeated.
// Reset empties the ring and clears the turn at once; the memory is not cleared, since an
// entry is read only after it has been written.
`default_nettype none

module round_robin_member_ring_unit
    import rrm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_t       rsp
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  turn_pos_reg, turn_pos_next;
    logic              turn_valid_reg, turn_valid_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  hit_reg, hit_next;
    logic [ID_W-1:0]   id_reg, id_next;
    status_t           status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_item_reg, out_item_next;

    logic              accept;
    logic              out_free;
    logic              emit;
    rsp_t              emit_item;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ID_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ID_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  turn_inc;
    logic [CNT_W-1:0]  count_dec;
    logic              list_last;
    logic              id_hit;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign turn_inc  = CNT_W'(turn_pos_reg) + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign list_last = (idx_inc == count_reg);
    assign id_hit    = (ram_rdata == id_reg);

    rrm_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_MEMBERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_ADD:
                            state_next = S_REPLY;
                        FUNC_LIST:
                            state_next = (count_reg == '0) ? S_REPLY : S_LIST_RD;
                        FUNC_REMOVE:
                            state_next = (count_reg == '0) ? S_REPLY : S_RM_RD;
                        FUNC_NEXT:
                            state_next = turn_valid_reg ? S_NX_RD : S_REPLY;
                        default:
                            state_next = S_REPLY;
                    endcase
                end
            end
            S_LIST_RD:
                state_next = S_LIST_EMIT;
            S_LIST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = list_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_RM_RD:
                state_next = S_RM_CMP;
            S_RM_CMP:
            begin
                if (id_hit)
                begin
                    state_next = S_SH_RD;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_RM_RD;
                end
            end
            S_SH_RD:
                state_next = (idx_reg == count_reg) ? S_RM_DONE : S_SH_WR;
            S_SH_WR:
                state_next = S_SH_RD;
            S_RM_DONE:
                state_next = S_REPLY;
            S_NX_RD:
                state_next = S_NX_EMIT;
            S_NX_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        turn_pos_next   = turn_pos_reg;
        turn_valid_next = turn_valid_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        id_next         = id_reg;
        status_next     = status_reg;
        emit            = 1'b0;
        emit_item       = '{member_id: '0, status: STAT_OK, last: 1'b1};
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_wdata       = req.player_id;
        ram_raddr       = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next     = req.player_id;
                    idx_next    = '0;
                    status_next = STAT_EMPTY;
                    if (req.func == FUNC_ADD)
                    begin
                        if (count_reg >= CNT_W'(MAX_MEMBERS))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = STAT_OK;
                            if (!turn_valid_reg)
                            begin
                                turn_valid_next = 1'b1;
                                turn_pos_next   = '0;
                            end
                        end
                    end
                end
            end
            S_LIST_EMIT:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_item = '{member_id: ram_rdata, status: STAT_OK, last: list_last};
                    idx_next  = idx_inc;
                end
            end
            S_RM_CMP:
            begin
                if (id_hit)
                begin
                    hit_next = idx_reg[IDX_W-1:0];
                    idx_next = idx_inc;
                end
                else if (idx_inc == count_reg)
                begin
                    status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(idx_reg - CNT_W'(1));
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
            end
            S_RM_DONE:
            begin
                count_next  = count_dec;
                status_next = STAT_OK;
                if (count_dec == '0)
                begin
                    turn_valid_next = 1'b0;
                    turn_pos_next   = '0;
                end
                else if (turn_valid_reg)
                begin
                    if (hit_reg < turn_pos_reg)
                    begin
                        turn_pos_next = turn_pos_reg - IDX_W'(1);
                    end
                    else if (hit_reg == turn_pos_reg && CNT_W'(turn_pos_reg) >= count_dec)
                    begin
                        turn_pos_next = '0;
                    end
                end
            end
            S_NX_RD:
                ram_raddr = turn_pos_reg;
            S_NX_EMIT:
            begin
                ram_raddr = turn_pos_reg;
                if (out_free)
                begin
                    emit          = 1'b1;
                    emit_item     = '{member_id: ram_rdata, status: STAT_OK, last: 1'b1};
                    turn_pos_next = (turn_inc >= count_reg) ? '0 : turn_inc[IDX_W-1:0];
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_item = '{member_id: '0, status: status_reg, last: 1'b1};
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !rsp_ready);
        out_item_next  = emit ? emit_item : out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            turn_pos_reg   <= '0;
            turn_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            turn_pos_reg   <= turn_pos_next;
            turn_valid_reg <= turn_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        id_reg       <= id_next;
        status_reg   <= status_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire
